// File: rtl/ssir_pkg.sv
// Shared types and constants for the sorted set insert/remove block.
// Used by the storage cell and by the top level; depends on nothing.
package ssir_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
  } ssir_item_t;

  typedef struct packed {
    logic       was_present;
    logic       changed;
    logic       dropped_full;
    logic [6:0] element_count;
  } ssir_result_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic cmp;  // register compare flags against the key
    logic ins;  // open a slot at the insert position and write the key
    logic rem;  // close the gap at the matching entry
  } ssir_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } ssir_state_e;

endpackage

// File: rtl/ssir_cell.sv
// One storage cell of the sorted row: holds a single entry and its compare flags.
// Depends on ssir_pkg for the command struct.
module ssir_cell
  import ssir_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssir_cmd_t          cmd_i,
  input  logic               active_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] left_entry_i,
  input  logic               left_below_i,
  input  logic signed [31:0] right_entry_i,
  output logic signed [31:0] entry_o,
  output logic               below_o,
  output logic               hit_o
);

  logic signed [31:0] entry_q, entry_d;
  logic               below_q, below_d;
  logic               hit_q, hit_d;

  always_comb begin
    below_d = below_q;
    hit_d   = hit_q;
    entry_d = entry_q;
    if (cmd_i.cmp) begin
      below_d = active_i && (entry_q < key_i);
      hit_d   = active_i && (entry_q == key_i);
    end
    if (cmd_i.ins) begin
      // Cells past the insert position take their left neighbor; the cell at it takes the key.
      if (!left_below_i) begin
        entry_d = left_entry_i;
      end else if (!below_q) begin
        entry_d = key_i;
      end
    end else if (cmd_i.rem) begin
      if (!below_q) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      below_q <= below_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign below_o = below_q;
  assign hit_o   = hit_q;

endmodule

// File: rtl/sorted_set_insert_remove.sv
// Top level of the sorted set: control sequencer, element count and a row of cells.
// Depends on ssir_pkg and ssir_cell.
//
// Usage. The block keeps a set of distinct signed 32-bit values in ascending
// order in a row of CAPACITY cells. A command transfer happens at a rising
// edge where start is high and busy is low; item_i carries the kind (insert
// or remove) and the value. Each command produces exactly one result on
// result_o, marked by done_o for a single cycle.
//
// Timing. After the command edge, the compare state lets every cell compare its entry
// against the key and register its flags; the update state then reduces the match
// flags and shifts the row by one place, left or right, in a single step.
// The result appears in the cycle after the update state, and busy drops in that
// same cycle, so the block takes no new command until the last one is through.
//
// Reset clears the element count and the sequencer; the stored entries are
// not cleared, since only entries below the count are ever looked at.
// The receiver cannot stall: each result is valid for exactly one cycle.
module sorted_set_insert_remove
  import ssir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  ssir_item_t   item_i,
  output logic         done_o,
  output ssir_result_t result_o
);

  ssir_state_e state_q, state_d;
  ssir_cmd_t   cmd;

  logic               kind_q;
  logic signed [31:0] key_q;
  logic [CNT_W-1:0]   count_q, count_d;
  ssir_result_t       result_q, result_d;
  logic               done_q, done_d;

  logic signed [31:0] entry [CAPACITY];
  logic [CAPACITY-1:0] below;
  logic [CAPACITY-1:0] hit;

  logic present;
  logic full;
  logic do_ins;
  logic do_rem;

  // The whole row reports a match through its registered hit flags.
  assign present = |hit;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign do_ins  = (kind_q == KIND_INSERT) && !present && !full;
  assign do_rem  = (kind_q == KIND_REMOVE) && present;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CMP;
      end
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy    = 1'b0;
    cmd.cmp = 1'b0;
    cmd.ins = 1'b0;
    cmd.rem = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_CMP: begin
        busy    = 1'b1;
        cmd.cmp = 1'b1;
      end
      ST_UPD: begin
        busy    = 1'b1;
        cmd.ins = do_ins;
        cmd.rem = do_rem;
      end
      default: busy = 1'b0;
    endcase
  end

  // Count and result are settled in the update cycle.
  always_comb begin
    count_d  = count_q;
    result_d = result_q;
    done_d   = 1'b0;
    if (state_q == ST_UPD) begin
      if (do_ins) begin
        count_d = count_q + CNT_W'(1);
      end else if (do_rem) begin
        count_d = count_q - CNT_W'(1);
      end
      result_d.was_present   = present;
      result_d.changed       = do_ins || do_rem;
      result_d.dropped_full  = (kind_q == KIND_INSERT) && !present && full;
      result_d.element_count = 7'(count_d);
      done_d                 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // The command is captured when it is taken; payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= item_i.kind;
      key_q  <= item_i.value;
    end
    result_q <= result_d;
  end

  // The row of cells. The first cell sees an always-below left neighbor,
  // so it takes the key when the insert position is zero. The last cell's
  // right neighbor is itself, which only matters past the valid entries.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_entry;
    logic               left_below;
    logic signed [31:0] right_entry;
    logic               active;

    assign active = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_entry = key_q;
      assign left_below = 1'b1;
    end else begin : g_mid
      assign left_entry = entry[i-1];
      assign left_below = below[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    ssir_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .active_i     (active),
      .key_i        (key_q),
      .left_entry_i (left_entry),
      .left_below_i (left_below),
      .right_entry_i(right_entry),
      .entry_o      (entry[i]),
      .below_o      (below[i]),
      .hit_o        (hit[i])
    );
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// File: bench/sorted_set_checker.sv
// Checker for the sorted set block: watches command and result transfers,
// keeps its own copy of the set, and compares each result field by field.
// Depends on ssir_pkg for the item and result types and the kind codes.
module sorted_set_checker
  import ssir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         busy,
  input  ssir_item_t   item_i,
  input  logic         done_o,
  input  ssir_result_t result_o,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the set, ascending, plus the results still owed by the block.
  logic signed [31:0] shadow_set[$];
  ssir_result_t       expected_results[$];
  ssir_result_t       oldest;
  int unsigned        result_seq  = 0;
  int unsigned        mismatches  = 0;
  int unsigned        outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [6:0] got, logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                result_seq, name, got, want));
  endtask

  // Applies one command to the shadow set and returns the result it must produce.
  function automatic ssir_result_t apply_update(ssir_item_t it);
    logic signed [31:0] key;
    int unsigned        pos;
    logic               hit;
    ssir_result_t       res;
    key = it.value;
    pos = 0;
    while (pos < shadow_set.size() && shadow_set[pos] < key) pos++;
    hit = (pos < shadow_set.size()) && (shadow_set[pos] == key);
    res = '0;
    res.was_present = hit;
    if (it.kind == KIND_INSERT) begin
      if (!hit) begin
        if (shadow_set.size() >= CAPACITY) begin
          res.dropped_full = 1'b1;
        end else begin
          shadow_set.insert(pos, key);
          res.changed = 1'b1;
        end
      end
    end else if (hit) begin
      shadow_set.delete(pos);
      res.changed = 1'b1;
    end
    res.element_count = 7'(shadow_set.size());
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_set.delete();
      expected_results.delete();
    end else begin
      // A result and a new command can share an edge; the result is the older one.
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no command outstanding",
                                    result_seq));
        end else begin
          oldest = expected_results.pop_front();
          compare_field("was_present", 7'(result_o.was_present), 7'(oldest.was_present));
          compare_field("changed", 7'(result_o.changed), 7'(oldest.changed));
          compare_field("dropped_full", 7'(result_o.dropped_full),
                        7'(oldest.dropped_full));
          compare_field("element_count", result_o.element_count, oldest.element_count);
        end
        result_seq++;
      end
      if (start && !busy) expected_results.push_back(apply_update(item_i));
    end
    outstanding = expected_results.size();
  end

endmodule

// File: bench/sorted_set_insert_remove_test.sv
// Top of the sorted set bench: clock, reset, command stimulus and the verdict.
// Depends on ssir_pkg, the block sorted_set_insert_remove and sorted_set_checker.
module sorted_set_insert_remove_test
  import ssir_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Rough number of commands to send before the run winds down.
  localparam int unsigned ITEM_TARGET = 900;

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  ssir_item_t   item_i;
  logic         done_o;
  ssir_result_t result_o;
  int unsigned  mismatches;
  int unsigned  outstanding;

  int unsigned        items_sent = 0;
  logic signed [31:0] value_pool[$];

  sorted_set_insert_remove u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // The checker sees exactly what the block sees and hands back two numbers:
  // the mismatch count for the verdict and the number of results still owed,
  // which the stimulus uses to wait for the block to go quiet.
  sorted_set_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .fail_count_o(mismatches),
    .pending_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle time between commands: usually none, sometimes a few cycles, and
  // now and then a long pause so that gaps land on every phase of the block.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Candidate values lean toward the two ends of the range, zero and minus one,
  // and a small cluster around zero, so that duplicates and hits are common.
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) begin
      case ($urandom_range(3, 0))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (roll < 40) return 32'($signed($urandom_range(16, 0)) - 8);
    return $urandom;
  endfunction

  task automatic build_pool(int unsigned entries);
    value_pool.delete();
    repeat (entries) value_pool.push_back(pick_value());
  endtask

  // Presents one command at a falling edge and holds it until the block takes
  // it, which is the rising edge where start is high and busy is low. With a
  // gap of zero, start simply stays high into the next command.
  task automatic issue(logic kind, logic signed [31:0] value, int unsigned gap);
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= '{kind: kind, value: value};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops sending and waits until every result owed by the block has come back.
  task automatic drain_all();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase_len;
    int unsigned insert_pct;
    bit          burst;
    logic        kind;
    logic signed [31:0] value;

    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, back to back. It touches both ends of the value range,
    // a duplicate insert, removes of absent values (including on an empty
    // set), removes of present values at the ends of the row, and both
    // alternating bit patterns, and it leaves the set empty again.
    issue(KIND_REMOVE, 32'sd7, 0);
    issue(KIND_INSERT, 32'h0000_0000, 0);
    issue(KIND_INSERT, 32'h8000_0000, 0);
    issue(KIND_INSERT, 32'h7FFF_FFFF, 0);
    issue(KIND_INSERT, 32'hFFFF_FFFF, 0);
    issue(KIND_INSERT, 32'h0000_0001, 0);
    issue(KIND_INSERT, 32'h0000_0000, 0);
    issue(KIND_REMOVE, 32'h0000_0005, 0);
    issue(KIND_REMOVE, 32'h8000_0000, 0);
    issue(KIND_REMOVE, 32'h7FFF_FFFF, 0);
    issue(KIND_REMOVE, 32'h7FFF_FFFF, 0);
    issue(KIND_INSERT, 32'h5555_5555, 0);
    issue(KIND_INSERT, 32'hAAAA_AAAA, 0);
    issue(KIND_INSERT, 32'h5555_5555, 0);
    issue(KIND_REMOVE, 32'hFFFF_FFFF, 0);
    issue(KIND_REMOVE, 32'h0000_0000, 0);
    issue(KIND_INSERT, 32'h7FFF_FFFF, 0);
    issue(KIND_REMOVE, 32'h0000_0001, 0);
    issue(KIND_REMOVE, 32'h5555_5555, 0);
    issue(KIND_REMOVE, 32'hAAAA_AAAA, 0);
    issue(KIND_REMOVE, 32'h7FFF_FFFF, 0);
    issue(KIND_REMOVE, 32'h0000_0000, 0);
    drain_all();

    // Fill phase: mostly inserts from a wide pool, long enough to reach the
    // capacity and then run into refused inserts on a full store.
    build_pool(200);
    repeat (110) begin
      kind = ($urandom_range(99, 0) < 95) ? KIND_INSERT : KIND_REMOVE;
      issue(kind, value_pool[$urandom_range(value_pool.size() - 1, 0)], pick_gap());
    end
    // Let the block go fully quiet once before the mixed traffic starts.
    drain_all();

    // Mixed phases. Each phase draws from its own pool and leans toward
    // inserts, toward removes, or neither, so the count rises to the top,
    // drains toward empty and wanders in between. A few commands per phase
    // are noise with a completely random kind and value.
    while (items_sent < ITEM_TARGET) begin
      phase_len = $urandom_range(100, 20);
      case ($urandom_range(2, 0))
        0: insert_pct = 90;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      case ($urandom_range(3, 0))
        0: build_pool(4);
        1: build_pool(24);
        2: build_pool(80);
        default: build_pool(200);
      endcase
      burst = ($urandom_range(3, 0) == 0);
      repeat (phase_len) begin
        if ($urandom_range(99, 0) < 5) begin
          kind  = $urandom_range(1, 0) ? KIND_REMOVE : KIND_INSERT;
          value = $urandom;
        end else begin
          kind  = ($urandom_range(99, 0) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
          value = value_pool[$urandom_range(value_pool.size() - 1, 0)];
        end
        issue(kind, value, burst ? 0 : pick_gap());
      end
      if ($urandom_range(3, 0) == 0) drain_all();
    end

    // Wind down: wait for the last results, then a few more cycles so a
    // stray late result would still be caught.
    drain_all();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Safety net against a block that stops answering or never drops busy.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/ssir_pkg.sv
rtl/ssir_cell.sv
rtl/sorted_set_insert_remove.sv
bench/sorted_set_checker.sv
bench/sorted_set_insert_remove_test.sv
